### rtl/core/two_link_leg_inverse_kinematics_unit_defines.svh
// assertion macros for the leg inverse kinematics unit
`ifndef TWO_LINK_LEG_INVERSE_KINEMATICS_UNIT_DEFINES_SVH
`define TWO_LINK_LEG_INVERSE_KINEMATICS_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TLIK_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlik assertion failed");

// next-cycle implication
`define TLIK_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlik assertion failed");

`else

`define TLIK_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define TLIK_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/core/tlik_pkg.sv
package tlik_pkg;

   // field widths
   localparam int COORD_W   = 18;
   localparam int LEN_W     = 16;
   localparam int HIP_W     = 17;
   localparam int KNEE_W    = 16;
   localparam int STATUS_W  = 2;

   // internal datapath widths
   localparam int M2_W      = 36;
   localparam int NUM_W     = 38;
   localparam int DEN_W     = 35;
   localparam int FRAC_BITS = 16;
   localparam int QUO_W     = FRAC_BITS + 1;
   localparam int COS_W     = QUO_W + 1;
   localparam int SIN_ARG_W = 34;
   localparam int SIN_W     = SIN_ARG_W / 2;
   localparam int CORD_W    = 42;
   localparam int CORD_SHIFT = 20;
   localparam int ANG_W     = 20;
   localparam int DIFF_W    = 22;

   // angle constants, 2^-16 rad
   localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 20'sd102944;
   localparam logic signed [ANG_W-1:0] ANG_PI      = 20'sd205887;

   // output clamps, 2^-13 rad
   localparam logic signed [DIFF_W-1:0] HIP_MIN  = -22'sd25736;
   localparam logic signed [DIFF_W-1:0] HIP_MAX  = 22'sd51472;
   localparam logic signed [DIFF_W-1:0] KNEE_MIN = -22'sd25736;
   localparam logic signed [DIFF_W-1:0] KNEE_MAX = 22'sd0;

   // solve status codes
   localparam logic [STATUS_W-1:0] ST_REACHABLE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_CLAMPED   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO      = 2'd2;

   // register addresses (word index)
   localparam logic REG_UPPER = 1'b0;
   localparam logic REG_LOWER = 1'b1;
   localparam logic [LEN_W-1:0] LEN_RESET = 16'd8520;

   // side data carried through the distance square root
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] z;
      logic signed [NUM_W-1:0]   num1;
      logic signed [NUM_W-1:0]   num2;
      logic [DEN_W-1:0]          den2;
      logic                      zero;
   } dist_side_type;

   // side data carried through the divider
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] z;
      logic                      zero;
   } div_side_type;

   // side data carried through the sine square root
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] z;
      logic signed [COS_W-1:0]   c1;
      logic signed [COS_W-1:0]   c2;
      logic                      bad;
      logic                      zero;
   } sine_side_type;

   // side data carried through the cordic
   typedef struct packed {
      logic bad;
      logic zero;
   } cord_side_type;

   // arctangent table, 2^-16 rad
   function automatic logic signed [ANG_W-1:0] cordic_atan(input int unsigned idx);
      logic signed [ANG_W-1:0] r;
      case (idx)
         0: r = 20'sd51472;
         1: r = 20'sd30386;
         2: r = 20'sd16055;
         3: r = 20'sd8150;
         4: r = 20'sd4091;
         5: r = 20'sd2047;
         6: r = 20'sd1024;
         7: r = 20'sd512;
         8: r = 20'sd256;
         9: r = 20'sd128;
         10: r = 20'sd64;
         11: r = 20'sd32;
         12: r = 20'sd16;
         13: r = 20'sd8;
         14: r = 20'sd4;
         15: r = 20'sd2;
         16: r = 20'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

### rtl/core/tlik_req_if.sv
interface tlik_req_if;
   logic valid;
   logic ready;
   logic signed [tlik_pkg::COORD_W-1:0] target_x;
   logic signed [tlik_pkg::COORD_W-1:0] target_z;

   modport source (output valid, output target_x, output target_z, input ready);
   modport sink (input valid, input target_x, input target_z, output ready);
endinterface

### rtl/core/tlik_rsp_if.sv
interface tlik_rsp_if;
   logic valid;
   logic ready;
   logic signed [tlik_pkg::HIP_W-1:0]  hip_angle;
   logic signed [tlik_pkg::KNEE_W-1:0] knee_angle;
   logic [tlik_pkg::STATUS_W-1:0]      solve_status;

   modport source (output valid, output hip_angle, output knee_angle, output solve_status,
                   input ready);
   modport sink (input valid, input hip_angle, input knee_angle, input solve_status,
                 output ready);
endinterface

### rtl/core/tlik_sqrt.sv
// pipelined integer square root, one root bit per stage
module tlik_sqrt #(
   parameter int W     = 36,
   parameter int LANES = 1,
   parameter int SW    = 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  logic [W-1:0]   in_value [LANES],
   input  logic [SW-1:0]  in_side,
   output logic           out_valid,
   output logic [W/2-1:0] out_root [LANES],
   output logic [SW-1:0]  out_side
);
   localparam int N = W / 2;

   logic          vld_ff  [N];
   logic [SW-1:0] side_ff [N];
   logic [W-1:0]  val_ff  [N][LANES];
   logic [N+1:0]  rem_ff  [N][LANES];
   logic [N-1:0]  root_ff [N][LANES];
   logic [N+1:0]  rem_in  [N][LANES];
   logic [N-1:0]  root_in [N][LANES];

   genvar s, l;
   for (s = 0; s < N; s++) begin : g_stage
      // valid and side data follow the stage
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= (s == 0) ? in_valid : vld_ff[(s == 0) ? 0 : s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[s] <= (s == 0) ? in_side : side_ff[(s == 0) ? 0 : s-1];
         end
      end

      for (l = 0; l < LANES; l++) begin : g_lane
         logic [W-1:0] val_pv;
         logic [N+1:0] rem_pv;
         logic [N-1:0] root_pv;
         logic [N+1:0] cur;
         logic [N+1:0] trial;
         logic         ge;

         if (s == 0) begin : g_first
            assign val_pv  = in_value[l];
            assign rem_pv  = '0;
            assign root_pv = '0;
         end else begin : g_next
            assign val_pv  = val_ff[s-1][l];
            assign rem_pv  = rem_ff[s-1][l];
            assign root_pv = root_ff[s-1][l];
         end

         // bring down two bits and try the next root bit
         assign cur   = {rem_pv[N-1:0], val_pv[W-1-2*s -: 2]};
         assign trial = {root_pv, 2'b01};
         assign ge    = (cur >= trial);
         assign rem_in[s][l]  = ge ? (cur - trial) : cur;
         assign root_in[s][l] = {root_pv[N-2:0], ge};

         always_ff @(posedge clock) begin
            if (en) begin
               val_ff[s][l]  <= val_pv;
               rem_ff[s][l]  <= rem_in[s][l];
               root_ff[s][l] <= root_in[s][l];
            end
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_side  = side_ff[N-1];
   for (l = 0; l < LANES; l++) begin : g_out
      assign out_root[l] = root_ff[N-1][l];
   end

endmodule

### rtl/core/tlik_div.sv
// pipelined saturating fractional divider, one quotient bit per stage
module tlik_div #(
   parameter int NW    = 38,
   parameter int DW    = 35,
   parameter int QW    = 17,
   parameter int LANES = 2,
   parameter int SW    = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic signed [NW-1:0] in_num [LANES],
   input  logic [DW-1:0]       in_den [LANES],
   input  logic [SW-1:0]       in_side,
   output logic                out_valid,
   output logic signed [QW:0]  out_cos [LANES],
   output logic                out_bad [LANES],
   output logic [SW-1:0]       out_side
);
   localparam int NS = QW + 1;
   localparam logic signed [QW:0] ONE = (QW+1)'(1) << (QW - 1);

   logic          vld_ff  [NS];
   logic [SW-1:0] side_ff [NS];
   logic [DW:0]   rem_ff  [NS][LANES];
   logic [DW-1:0] den_ff  [NS][LANES];
   logic [QW-1:0] quo_ff  [NS][LANES];
   logic          neg_ff  [NS][LANES];
   logic          bad_ff  [NS][LANES];

   logic                out_vld_ff;
   logic [SW-1:0]       out_side_ff;
   logic signed [QW:0]  cos_ff [LANES];
   logic                obad_ff [LANES];

   genvar s, l;
   for (s = 0; s < NS; s++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= (s == 0) ? in_valid : vld_ff[(s == 0) ? 0 : s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[s] <= (s == 0) ? in_side : side_ff[(s == 0) ? 0 : s-1];
         end
      end

      for (l = 0; l < LANES; l++) begin : g_lane
         if (s == 0) begin : g_entry
            logic          neg;
            logic [NW-1:0] anum;
            logic          bad;

            // magnitude and range check
            assign neg  = in_num[l][NW-1];
            assign anum = neg ? NW'(-in_num[l]) : NW'(in_num[l]);
            assign bad  = (in_den[l] == '0) || (anum > NW'(in_den[l]));

            always_ff @(posedge clock) begin
               if (en) begin
                  rem_ff[s][l] <= bad ? '0 : (DW+1)'(anum);
                  den_ff[s][l] <= in_den[l];
                  quo_ff[s][l] <= '0;
                  neg_ff[s][l] <= neg;
                  bad_ff[s][l] <= bad;
               end
            end
         end else begin : g_iter
            logic          ge;
            logic [DW:0]   rem;

            // restoring division step
            assign ge  = rem_ff[s-1][l] >= {1'b0, den_ff[s-1][l]};
            assign rem = ge ? (rem_ff[s-1][l] - {1'b0, den_ff[s-1][l]}) : rem_ff[s-1][l];

            always_ff @(posedge clock) begin
               if (en) begin
                  rem_ff[s][l] <= {rem[DW-1:0], 1'b0};
                  den_ff[s][l] <= den_ff[s-1][l];
                  quo_ff[s][l] <= {quo_ff[s-1][l][QW-2:0], ge};
                  neg_ff[s][l] <= neg_ff[s-1][l];
                  bad_ff[s][l] <= bad_ff[s-1][l];
               end
            end
         end
      end
   end

   // apply sign or saturate
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_side_ff <= side_ff[NS-1];
      end
   end

   for (l = 0; l < LANES; l++) begin : g_out
      logic signed [QW:0] mag;
      assign mag = bad_ff[NS-1][l] ? ONE : $signed({1'b0, quo_ff[NS-1][l]});

      always_ff @(posedge clock) begin
         if (en) begin
            cos_ff[l]  <= neg_ff[NS-1][l] ? -mag : mag;
            obad_ff[l] <= bad_ff[NS-1][l];
         end
      end

      assign out_cos[l] = cos_ff[l];
      assign out_bad[l] = obad_ff[l];
   end

   assign out_valid = out_vld_ff;
   assign out_side  = out_side_ff;

endmodule

### rtl/core/tlik_cordic.sv
// pipelined vectoring cordic, atan2(y, x) per lane, one rotation per stage
module tlik_cordic #(
   parameter int XW     = 42,
   parameter int AW     = 20,
   parameter int STAGES = 16,
   parameter int LANES  = 3,
   parameter int SW     = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [XW-1:0] in_y [LANES],
   input  logic signed [XW-1:0] in_x [LANES],
   input  logic [SW-1:0]        in_side,
   output logic                 out_valid,
   output logic signed [AW-1:0] out_angle [LANES],
   output logic [SW-1:0]        out_side
);
   localparam int NS = STAGES + 1;

   logic                 vld_ff  [NS];
   logic [SW-1:0]        side_ff [NS];
   logic signed [XW-1:0] x_ff    [NS][LANES];
   logic signed [XW-1:0] y_ff    [NS][LANES];
   logic signed [AW-1:0] a_ff    [NS][LANES];

   genvar s, l;
   for (s = 0; s < NS; s++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= (s == 0) ? in_valid : vld_ff[(s == 0) ? 0 : s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[s] <= (s == 0) ? in_side : side_ff[(s == 0) ? 0 : s-1];
         end
      end

      for (l = 0; l < LANES; l++) begin : g_lane
         if (s == 0) begin : g_pre
            // quarter turn into the right half plane
            always_ff @(posedge clock) begin
               if (en) begin
                  if (in_x[l] < 0 && in_y[l] >= 0) begin
                     x_ff[s][l] <= in_y[l];
                     y_ff[s][l] <= -in_x[l];
                     a_ff[s][l] <= AW'(tlik_pkg::ANG_HALF_PI);
                  end else if (in_x[l] < 0) begin
                     x_ff[s][l] <= -in_y[l];
                     y_ff[s][l] <= in_x[l];
                     a_ff[s][l] <= -AW'(tlik_pkg::ANG_HALF_PI);
                  end else begin
                     x_ff[s][l] <= in_x[l];
                     y_ff[s][l] <= in_y[l];
                     a_ff[s][l] <= '0;
                  end
               end
            end
         end else begin : g_rot
            localparam logic signed [AW-1:0] STEP_ANG = AW'(tlik_pkg::cordic_atan(s - 1));
            logic signed [XW-1:0] dx;
            logic signed [XW-1:0] dy;

            assign dx = y_ff[s-1][l] >>> (s - 1);
            assign dy = x_ff[s-1][l] >>> (s - 1);

            // rotate toward the x axis
            always_ff @(posedge clock) begin
               if (en) begin
                  if (y_ff[s-1][l] >= 0) begin
                     x_ff[s][l] <= x_ff[s-1][l] + dx;
                     y_ff[s][l] <= y_ff[s-1][l] - dy;
                     a_ff[s][l] <= a_ff[s-1][l] + STEP_ANG;
                  end else begin
                     x_ff[s][l] <= x_ff[s-1][l] - dx;
                     y_ff[s][l] <= y_ff[s-1][l] + dy;
                     a_ff[s][l] <= a_ff[s-1][l] - STEP_ANG;
                  end
               end
            end
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_side  = side_ff[NS-1];
   for (l = 0; l < LANES; l++) begin : g_out
      assign out_angle[l] = a_ff[NS-1][l];
   end

endmodule

### rtl/core/two_link_leg_inverse_kinematics_unit.sv
// Two-link leg inverse kinematics: each request carries a foot target (x, z) in 2^-16 m and
// returns hip and knee angles in 2^-13 rad with a solve status (reachable, cosine clamped,
// zero distance). The unit is a single pipeline that takes one request every clock and
// returns each response through the bit-per-stage square roots and divider and the cordic
// stages. A response held on the output stalls the whole pipeline, and requests are taken
// again as soon as it is taken. Link lengths must be written over the register port only
// while no request is in flight; the unit itself does not enforce this.
`include "two_link_leg_inverse_kinematics_unit_defines.svh"

module two_link_leg_inverse_kinematics_unit #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   tlik_req_if.sink    req_bus,
   tlik_rsp_if.source  rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int CW = tlik_pkg::COORD_W;
   localparam int LW = tlik_pkg::LEN_W;

   // link length registers
   logic [LW-1:0] upper_ff;
   logic [LW-1:0] lower_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= tlik_pkg::LEN_RESET;
         lower_ff <= tlik_pkg::LEN_RESET;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == tlik_pkg::REG_UPPER) begin
            upper_ff <= pwdata[LW-1:0];
         end else begin
            lower_ff <= pwdata[LW-1:0];
         end
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == tlik_pkg::REG_UPPER) ? {16'b0, upper_ff} : {16'b0, lower_ff};

   // global advance: move whenever the output slot is free or being taken
   logic en;
   logic rsp_vld_ff;
   assign en = !rsp_vld_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   // stage a: request capture
   logic                 a_vld_ff;
   logic signed [CW-1:0] a_x_ff;
   logic signed [CW-1:0] a_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_x_ff <= req_bus.target_x;
         a_z_ff <= req_bus.target_z;
      end
   end

   // stage b: squares and link products
   logic                 b_vld_ff;
   logic signed [CW-1:0] b_x_ff;
   logic signed [CW-1:0] b_z_ff;
   logic [35:0]          b_xx_ff;
   logic [35:0]          b_zz_ff;
   logic [31:0]          b_l1sq_ff;
   logic [31:0]          b_l2sq_ff;
   logic [31:0]          b_l12_ff;
   logic signed [35:0]   xx_in;
   logic signed [35:0]   zz_in;

   assign xx_in = a_x_ff * a_x_ff;
   assign zz_in = a_z_ff * a_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_x_ff    <= a_x_ff;
         b_z_ff    <= a_z_ff;
         b_xx_ff   <= xx_in;
         b_zz_ff   <= zz_in;
         b_l1sq_ff <= upper_ff * upper_ff;
         b_l2sq_ff <= lower_ff * lower_ff;
         b_l12_ff  <= upper_ff * lower_ff;
      end
   end

   // stage c: squared distance and cosine numerators
   logic                    c_vld_ff;
   logic [tlik_pkg::M2_W-1:0] c_m2_ff;
   tlik_pkg::dist_side_type c_side_ff;
   logic [tlik_pkg::M2_W-1:0] m2_in;
   logic signed [tlik_pkg::NUM_W-1:0] l1sq_s;
   logic signed [tlik_pkg::NUM_W-1:0] l2sq_s;
   logic signed [tlik_pkg::NUM_W-1:0] m2_s;

   assign m2_in  = b_xx_ff + b_zz_ff;
   assign l1sq_s = $signed(tlik_pkg::NUM_W'(b_l1sq_ff));
   assign l2sq_s = $signed(tlik_pkg::NUM_W'(b_l2sq_ff));
   assign m2_s   = $signed(tlik_pkg::NUM_W'(m2_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_m2_ff         <= m2_in;
         c_side_ff.x     <= b_x_ff;
         c_side_ff.z     <= b_z_ff;
         c_side_ff.num1  <= l1sq_s + m2_s - l2sq_s;
         c_side_ff.num2  <= l1sq_s + l2sq_s - m2_s;
         c_side_ff.den2  <= {2'b0, b_l12_ff, 1'b0};
         c_side_ff.zero  <= (b_xx_ff == '0) && (b_zz_ff == '0);
      end
   end

   // distance square root
   localparam int DSW = $bits(tlik_pkg::dist_side_type);
   logic                      dist_vld;
   logic [tlik_pkg::M2_W-1:0] dist_val [1];
   logic [tlik_pkg::M2_W/2-1:0] dist_root [1];
   logic [DSW-1:0]            dist_side_bits;
   tlik_pkg::dist_side_type   dist_side;

   assign dist_val[0] = c_m2_ff;

   tlik_sqrt #(
      .W     (tlik_pkg::M2_W),
      .LANES (1),
      .SW    (DSW)
   ) u_dist_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_vld_ff),
      .in_value  (dist_val),
      .in_side   (c_side_ff),
      .out_valid (dist_vld),
      .out_root  (dist_root),
      .out_side  (dist_side_bits)
   );

   assign dist_side = tlik_pkg::dist_side_type'(dist_side_bits);

   // stage d: hip cosine denominator
   logic                              d_vld_ff;
   logic [tlik_pkg::DEN_W-1:0]        d_den1_ff;
   tlik_pkg::dist_side_type           d_side_ff;
   logic [33:0]                       ml1;

   assign ml1 = dist_root[0] * upper_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (en) begin
         d_vld_ff <= dist_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_den1_ff <= {ml1, 1'b0};
         d_side_ff <= dist_side;
      end
   end

   // cosine dividers
   localparam int VSW = $bits(tlik_pkg::div_side_type);
   logic signed [tlik_pkg::NUM_W-1:0] div_num [2];
   logic [tlik_pkg::DEN_W-1:0]        div_den [2];
   tlik_pkg::div_side_type            div_side_in;
   logic                              div_vld;
   logic signed [tlik_pkg::COS_W-1:0] div_cos [2];
   logic                              div_bad [2];
   logic [VSW-1:0]                    div_side_bits;
   tlik_pkg::div_side_type            div_side;

   assign div_num[0]       = d_side_ff.num1;
   assign div_num[1]       = d_side_ff.num2;
   assign div_den[0]       = d_den1_ff;
   assign div_den[1]       = d_side_ff.den2;
   assign div_side_in.x    = d_side_ff.x;
   assign div_side_in.z    = d_side_ff.z;
   assign div_side_in.zero = d_side_ff.zero;

   tlik_div #(
      .NW    (tlik_pkg::NUM_W),
      .DW    (tlik_pkg::DEN_W),
      .QW    (tlik_pkg::QUO_W),
      .LANES (2),
      .SW    (VSW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_vld_ff),
      .in_num    (div_num),
      .in_den    (div_den),
      .in_side   (div_side_in),
      .out_valid (div_vld),
      .out_cos   (div_cos),
      .out_bad   (div_bad),
      .out_side  (div_side_bits)
   );

   assign div_side = tlik_pkg::div_side_type'(div_side_bits);

   // stage e: one minus cosine squared
   logic                               e_vld_ff;
   logic [tlik_pkg::SIN_ARG_W-1:0]     e_arg_ff [2];
   tlik_pkg::sine_side_type            e_side_ff;
   logic signed [2*tlik_pkg::COS_W-1:0] csq [2];

   assign csq[0] = div_cos[0] * div_cos[0];
   assign csq[1] = div_cos[1] * div_cos[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (en) begin
         e_vld_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_arg_ff[0]    <= (tlik_pkg::SIN_ARG_W'(1) << (2 * tlik_pkg::FRAC_BITS))
                           - csq[0][tlik_pkg::SIN_ARG_W-1:0];
         e_arg_ff[1]    <= (tlik_pkg::SIN_ARG_W'(1) << (2 * tlik_pkg::FRAC_BITS))
                           - csq[1][tlik_pkg::SIN_ARG_W-1:0];
         e_side_ff.x    <= div_side.x;
         e_side_ff.z    <= div_side.z;
         e_side_ff.c1   <= div_cos[0];
         e_side_ff.c2   <= div_cos[1];
         e_side_ff.bad  <= div_bad[0] || div_bad[1];
         e_side_ff.zero <= div_side.zero;
      end
   end

   // sine square roots
   localparam int SSW = $bits(tlik_pkg::sine_side_type);
   logic                         sine_vld;
   logic [tlik_pkg::SIN_W-1:0]   sine_root [2];
   logic [SSW-1:0]               sine_side_bits;
   tlik_pkg::sine_side_type      sine_side;

   tlik_sqrt #(
      .W     (tlik_pkg::SIN_ARG_W),
      .LANES (2),
      .SW    (SSW)
   ) u_sine_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (e_vld_ff),
      .in_value  (e_arg_ff),
      .in_side   (e_side_ff),
      .out_valid (sine_vld),
      .out_root  (sine_root),
      .out_side  (sine_side_bits)
   );

   assign sine_side = tlik_pkg::sine_side_type'(sine_side_bits);

   // angle cordics: base direction, hip and knee arc cosines
   localparam int KW = tlik_pkg::CORD_W;
   localparam int CSW = $bits(tlik_pkg::cord_side_type);
   logic signed [KW-1:0]             cord_y [3];
   logic signed [KW-1:0]             cord_x [3];
   tlik_pkg::cord_side_type          cord_side_in;
   logic                             cord_vld;
   logic signed [tlik_pkg::ANG_W-1:0] cord_ang [3];
   logic [CSW-1:0]                   cord_side_bits;
   tlik_pkg::cord_side_type          cord_side;

   assign cord_y[0] = KW'(sine_side.x) <<< tlik_pkg::CORD_SHIFT;
   assign cord_x[0] = KW'(sine_side.z) <<< tlik_pkg::CORD_SHIFT;
   assign cord_y[1] = KW'($signed({1'b0, sine_root[0]})) <<< tlik_pkg::CORD_SHIFT;
   assign cord_x[1] = KW'(sine_side.c1) <<< tlik_pkg::CORD_SHIFT;
   assign cord_y[2] = KW'($signed({1'b0, sine_root[1]})) <<< tlik_pkg::CORD_SHIFT;
   assign cord_x[2] = KW'(sine_side.c2) <<< tlik_pkg::CORD_SHIFT;
   assign cord_side_in.bad  = sine_side.bad;
   assign cord_side_in.zero = sine_side.zero;

   tlik_cordic #(
      .XW     (KW),
      .AW     (tlik_pkg::ANG_W),
      .STAGES (CORDIC_STAGES),
      .LANES  (3),
      .SW     (CSW)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sine_vld),
      .in_y      (cord_y),
      .in_x      (cord_x),
      .in_side   (cord_side_in),
      .out_valid (cord_vld),
      .out_angle (cord_ang),
      .out_side  (cord_side_bits)
   );

   assign cord_side = tlik_pkg::cord_side_type'(cord_side_bits);

   // output stage: combine, round, clamp
   localparam int DW2 = tlik_pkg::DIFF_W;
   logic signed [DW2-1:0] hip_raw;
   logic signed [DW2-1:0] knee_raw;
   logic signed [DW2-1:0] hip_rnd;
   logic signed [DW2-1:0] knee_rnd;
   logic signed [DW2-1:0] hip_clip;
   logic signed [DW2-1:0] knee_clip;

   assign hip_raw  = DW2'(cord_ang[1]) - DW2'(cord_ang[0]);
   assign knee_raw = DW2'(cord_ang[2]) - DW2'(tlik_pkg::ANG_PI);
   assign hip_rnd  = (hip_raw + DW2'(4)) >>> 3;
   assign knee_rnd = (knee_raw + DW2'(4)) >>> 3;
   assign hip_clip = (hip_rnd < tlik_pkg::HIP_MIN) ? tlik_pkg::HIP_MIN :
                     (hip_rnd > tlik_pkg::HIP_MAX) ? tlik_pkg::HIP_MAX : hip_rnd;
   assign knee_clip = (knee_rnd < tlik_pkg::KNEE_MIN) ? tlik_pkg::KNEE_MIN :
                      (knee_rnd > tlik_pkg::KNEE_MAX) ? tlik_pkg::KNEE_MAX : knee_rnd;

   logic signed [tlik_pkg::HIP_W-1:0]  hip_ff;
   logic signed [tlik_pkg::KNEE_W-1:0] knee_ff;
   logic [tlik_pkg::STATUS_W-1:0]      status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= cord_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (cord_side.zero) begin
            hip_ff    <= '0;
            knee_ff   <= '0;
            status_ff <= tlik_pkg::ST_ZERO;
         end else begin
            hip_ff    <= hip_clip[tlik_pkg::HIP_W-1:0];
            knee_ff   <= knee_clip[tlik_pkg::KNEE_W-1:0];
            status_ff <= cord_side.bad ? tlik_pkg::ST_CLAMPED : tlik_pkg::ST_REACHABLE;
         end
      end
   end

   assign rsp_bus.valid        = rsp_vld_ff;
   assign rsp_bus.hip_angle    = hip_ff;
   assign rsp_bus.knee_angle   = knee_ff;
   assign rsp_bus.solve_status = status_ff;

   // checks
   `TLIK_ASSERT_SAME(zero_gives_zero_angles, clock, reset, rsp_vld_ff && status_ff == tlik_pkg::ST_ZERO, hip_ff == '0 && knee_ff == '0)
   `TLIK_ASSERT_SAME(knee_never_positive, clock, reset, rsp_vld_ff, knee_ff <= 0)
   `TLIK_ASSERT_SAME(stall_only_on_held_output, clock, reset, !req_bus.ready, rsp_vld_ff && !rsp_bus.ready)
   `TLIK_ASSERT_NEXT(held_output_stays, clock, reset, rsp_vld_ff && !rsp_bus.ready, rsp_vld_ff && $stable(status_ff))

endmodule
